FILE: src/psa_pkg.sv
package psa_pkg;

   // Field widths fixed by the interface
   localparam int OPCODE_W  = 1;
   localparam int PRIO_W    = 3;
   localparam int OUTCOME_W = 3;
   localparam int CREDIT_W  = 16;
   localparam int CFG_W     = 4;

   // Reset value of the active level count
   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   // Request opcodes
   localparam logic [OPCODE_W-1:0] OP_WAIT = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_POST = 1'b1;

   // Result codes
   localparam logic [OUTCOME_W-1:0] OC_PASSED = 3'd0;
   localparam logic [OUTCOME_W-1:0] OC_QUEUED = 3'd1;
   localparam logic [OUTCOME_W-1:0] OC_WOKE   = 3'd2;
   localparam logic [OUTCOME_W-1:0] OC_BANKED = 3'd3;
   localparam logic [OUTCOME_W-1:0] OC_REJECT = 3'd4;

   typedef logic [OPCODE_W-1:0]  opcode_type;
   typedef logic [PRIO_W-1:0]    prio_type;
   typedef logic [OUTCOME_W-1:0] outcome_type;

endpackage

FILE: src/priority_semaphore_arbiter_core.sv
// Priority counting semaphore. A request (wait or post) is taken whenever
// start is high and busy is low; busy is high only during reset and in the
// cycle that follows it, so one item is accepted per clock. Each item yields
// exactly one result: the item is registered at the accepting edge, resolved
// against the credit counter and the per-level waiter counters in the next
// cycle, and its result is registered and shown for one cycle with rsp_strobe
// high. The receiver cannot stall; every result must be taken when it is
// strobed. The user must write the level count register through the csr_
// channel only while no item is in flight; the block does not enforce it.
// A post wakes the lowest-numbered active level that has a waiter.
module priority_semaphore_arbiter_core #(
   parameter int MAX_LEVELS = 8,
   parameter int COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  psa_pkg::opcode_type    req_opcode,
   input  psa_pkg::prio_type      req_priority_req,
   output logic                   rsp_strobe,
   output psa_pkg::outcome_type   rsp_outcome,
   output psa_pkg::prio_type      rsp_woken_priority,
   output logic [15:0]            rsp_credits_left,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [3:0]             csr_data
);
   import psa_pkg::*;

   localparam int IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int LIM_W = ($clog2(MAX_LEVELS + 1) > CFG_W) ? $clog2(MAX_LEVELS + 1) : CFG_W;
   localparam logic [LIM_W-1:0] MAX_LIMIT = LIM_W'(MAX_LEVELS);

   typedef logic [COUNT_BITS-1:0] count_type;

   logic                  busy_ff;
   logic [CFG_W-1:0]      levels_ff;
   logic                  req_valid_ff;
   opcode_type            req_op_ff;
   prio_type              req_prio_ff;
   count_type             credits_ff, credits_in;
   count_type             waiters_ff [MAX_LEVELS];
   count_type             waiters_in [MAX_LEVELS];
   logic                  rsp_strobe_ff;
   outcome_type           outcome_ff, outcome_in;
   prio_type              woken_ff, woken_in;
   logic [LIM_W-1:0]      limit;
   logic                  found;
   logic [IDX_W-1:0]      first_idx;
   logic                  full_sel;

   // Hold off requests for the cycle after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

   // Level count register
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         levels_ff <= csr_data;
      end
   end

   // Register the accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_op_ff   <= req_opcode;
      req_prio_ff <= req_priority_req;
   end

   // Clamp the level count to the levels built
   always_comb begin
      if (LIM_W'(levels_ff) > MAX_LIMIT) begin
         limit = MAX_LIMIT;
      end else begin
         limit = LIM_W'(levels_ff);
      end
   end

   // Find the lowest active level with a waiter
   always_comb begin
      found     = 1'b0;
      first_idx = '0;
      for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
         if ((waiters_ff[i] != '0) && (i < int'(limit))) begin
            found     = 1'b1;
            first_idx = IDX_W'(i);
         end
      end
   end

   // Pick the full flag of the requested level
   always_comb begin
      full_sel = 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
         if (int'(req_prio_ff) == i) begin
            full_sel = (waiters_ff[i] == '1);
         end
      end
   end

   // Resolve the item against the counters
   always_comb begin
      credits_in = credits_ff;
      outcome_in = OC_REJECT;
      woken_in   = '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
         waiters_in[i] = waiters_ff[i];
      end
      if (req_valid_ff) begin
         if (req_op_ff == OP_WAIT) begin
            if (int'(req_prio_ff) >= int'(limit)) begin
               outcome_in = OC_REJECT;
            end else if (credits_ff != '0) begin
               credits_in = credits_ff - count_type'(1);
               outcome_in = OC_PASSED;
            end else if (full_sel) begin
               outcome_in = OC_REJECT;
            end else begin
               for (int i = 0; i < MAX_LEVELS; i++) begin
                  if (int'(req_prio_ff) == i) begin
                     waiters_in[i] = waiters_ff[i] + count_type'(1);
                  end
               end
               outcome_in = OC_QUEUED;
            end
         end else begin
            if (found) begin
               for (int i = 0; i < MAX_LEVELS; i++) begin
                  if (int'(first_idx) == i) begin
                     waiters_in[i] = waiters_ff[i] - count_type'(1);
                  end
               end
               woken_in   = PRIO_W'(first_idx);
               outcome_in = OC_WOKE;
            end else if (credits_ff == '1) begin
               outcome_in = OC_REJECT;
            end else begin
               credits_in = credits_ff + count_type'(1);
               outcome_in = OC_BANKED;
            end
         end
      end
   end

   // Advance the counters
   always_ff @(posedge clock) begin
      if (reset) begin
         credits_ff <= count_type'(1);
         for (int i = 0; i < MAX_LEVELS; i++) begin
            waiters_ff[i] <= '0;
         end
      end else begin
         credits_ff <= credits_in;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            waiters_ff[i] <= waiters_in[i];
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      outcome_ff <= outcome_in;
      woken_ff   <= woken_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_outcome        = outcome_ff;
   assign rsp_woken_priority = woken_ff;
   assign rsp_credits_left   = CREDIT_W'(credits_ff);

endmodule

FILE: bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import psa_pkg::*;

   localparam int          LEVELS       = 8;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
   localparam int          DRAIN_CYCLES = 6;
   localparam int          CYCLE_LIMIT  = 1_200_000;

   typedef struct packed {
      outcome_type outcome;
      prio_type    woken;
      logic [15:0] credits;
   } sem_result_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             start       = 1'b0;
   logic             busy;
   opcode_type       req_opcode       = OP_WAIT;
   prio_type         req_priority_req = '0;
   logic             rsp_strobe;
   outcome_type      rsp_outcome;
   prio_type         rsp_woken_priority;
   logic [15:0]      rsp_credits_left;
   logic             csr_valid   = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data    = '0;

   // Mirror of the semaphore state
   logic [CFG_W-1:0] level_count = CFG_RESET;
   logic [15:0]      credit_count = 16'd1;
   logic [15:0]      waiter_count [LEVELS] = '{default: 16'd0};

   sem_result_type pending_results [$];
   sem_result_type checked_result;
   int             mismatch_count = 0;
   int             cycle_count    = 0;

   priority_semaphore_arbiter_core u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_priority_req  (req_priority_req),
      .rsp_strobe        (rsp_strobe),
      .rsp_outcome       (rsp_outcome),
      .rsp_woken_priority(rsp_woken_priority),
      .rsp_credits_left  (rsp_credits_left),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Number of levels actually served
   function automatic int served_levels();
      return (level_count > LEVELS) ? LEVELS : int'(level_count);
   endfunction

   // Resolve one request against the mirrored counters
   function automatic sem_result_type resolve_request(opcode_type op, prio_type prio);
      sem_result_type res;
      int             limit;
      int             i;
      logic           found;
      limit = served_levels();
      found = 1'b0;
      res.woken = '0;
      if (op == OP_WAIT) begin
         if (int'(prio) >= limit) begin
            res.outcome = OC_REJECT;
         end else if (credit_count != 0) begin
            credit_count = credit_count - 16'd1;
            res.outcome = OC_PASSED;
         end else if (waiter_count[prio] == COUNT_MAX) begin
            res.outcome = OC_REJECT;
         end else begin
            waiter_count[prio] = waiter_count[prio] + 16'd1;
            res.outcome = OC_QUEUED;
         end
      end else begin
         for (i = 0; i < limit; i++) begin
            if (!found && waiter_count[i] != 0) begin
               waiter_count[i] = waiter_count[i] - 16'd1;
               res.woken = prio_type'(i);
               found = 1'b1;
            end
         end
         if (found) begin
            res.outcome = OC_WOKE;
         end else if (credit_count == COUNT_MAX) begin
            res.outcome = OC_REJECT;
         end else begin
            credit_count = credit_count + 16'd1;
            res.outcome = OC_BANKED;
         end
      end
      res.credits = credit_count;
      return res;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t ns %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Present one item and hold it until taken
   task automatic send_item(opcode_type op, prio_type prio);
      start            <= 1'b1;
      req_opcode       <= op;
      req_priority_req <= prio;
      do @(posedge clock); while (busy);
      pending_results.push_back(resolve_request(op, prio));
   endtask

   task automatic idle_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Drop start and let every pending result come back
   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_level_count(logic [CFG_W-1:0] value);
      wait_for_drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      level_count = value;
      csr_valid <= 1'b0;
   endtask

   // Hand-picked walk through passing, queuing, waking, range and shrink cases
   task automatic test_directed_sequence();
      send_item(OP_WAIT, 3'd0);
      send_item(OP_WAIT, 3'd7);
      send_item(OP_WAIT, 3'd3);
      send_item(OP_WAIT, 3'd3);
      send_item(OP_POST, 3'd5);
      send_item(OP_POST, 3'd0);
      send_item(OP_POST, 3'd7);
      send_item(OP_POST, 3'd2);
      send_item(OP_POST, 3'd0);
      send_item(OP_WAIT, 3'd5);
      write_level_count(4'd3);
      send_item(OP_WAIT, 3'd3);
      send_item(OP_WAIT, 3'd7);
      send_item(OP_WAIT, 3'd2);
      send_item(OP_WAIT, 3'd2);
      send_item(OP_WAIT, 3'd0);
      write_level_count(4'd1);
      send_item(OP_POST, 3'd1);
      send_item(OP_POST, 3'd1);
      send_item(OP_WAIT, 3'd1);
      write_level_count(4'd0);
      send_item(OP_WAIT, 3'd0);
      send_item(OP_POST, 3'd4);
      write_level_count(4'd15);
      send_item(OP_POST, 3'd6);
      send_item(OP_POST, 3'd6);
      send_item(OP_WAIT, 3'd7);
      write_level_count(CFG_RESET);
   endtask

   // Bursts of waits and posts with random content and level count
   task automatic test_random_traffic(int idle_pct, int n_items, logic [CFG_W-1:0] first_cfg);
      int sent;
      int burst;
      int post_bias;
      int limit;
      int next_cfg;
      opcode_type op;
      prio_type   prio;
      sent = 0;
      next_cfg = 0;
      write_level_count(first_cfg);
      while (sent < n_items) begin
         if (sent >= next_cfg + 100) begin
            next_cfg = sent;
            if ($urandom_range(0, 99) < 75)
               write_level_count(CFG_W'($urandom_range(1, 8)));
            else
               write_level_count(CFG_W'($urandom_range(0, 15)));
         end
         burst = $urandom_range(1, 16);
         post_bias = $urandom_range(0, 100);
         repeat (burst) begin
            limit = served_levels();
            op = ($urandom_range(0, 99) < post_bias) ? OP_POST : OP_WAIT;
            if (limit > 0 && $urandom_range(0, 99) < 85)
               prio = prio_type'($urandom_range(0, limit - 1));
            else
               prio = prio_type'($urandom_range(0, 7));
            while ($urandom_range(0, 99) < idle_pct)
               idle_cycles(1);
            send_item(op, prio);
            sent++;
         end
      end
   endtask

   // Compare each strobed result with the oldest pending one
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_outcome, 0);
         end else begin
            checked_result = pending_results.pop_front();
            if (rsp_outcome !== checked_result.outcome)
               report_mismatch("outcome", rsp_outcome, checked_result.outcome);
            if (rsp_woken_priority !== checked_result.woken)
               report_mismatch("woken_priority", rsp_woken_priority, checked_result.woken);
            if (rsp_credits_left !== checked_result.credits)
               report_mismatch("credits_left", rsp_credits_left, checked_result.credits);
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("priority_semaphore_arbiter_core: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_sequence();
      test_random_traffic(9, 500, 4'd1);
      test_random_traffic(48, 500, CFG_RESET);
      test_random_traffic(0, 500, 4'd15);
      wait_for_drain();
      if (mismatch_count == 0)
         $display("priority_semaphore_arbiter_core: match");
      else
         $display("priority_semaphore_arbiter_core: mismatch");
      $finish;
   end

endmodule

FILE: sim.f
src/psa_pkg.sv
src/priority_semaphore_arbiter_core.sv
bench/tb_top.sv
